### design/tpsbs_pkg.sv
// Shared constants and types for the threshold prefix sorter.
package tpsbs_pkg;

  localparam int PREFIX_MAX = 64;
  localparam int POS_W      = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
  localparam int CNT_W      = $clog2(PREFIX_MAX + 1);
  localparam int IMP_W      = 8;
  localparam int SEQ_W      = 16;
  localparam int OUT_POS_W  = 6;
  localparam int OUT_CNT_W  = 7;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic             keep;
    logic             eor;
    logic [SEQ_W-1:0] seq;
    logic [POS_W-1:0] pos;
  } q_entry_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [POS_W-1:0] pos;
  } cell_t;

  typedef enum logic {
    BK_COLLECT,
    BK_EMIT
  } bk_state_t;

endpackage

### design/tpsbs_front.sv
// Front end: threshold compare, prefix tracking and queue push.
module tpsbs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tpsbs_pkg::IMP_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tpsbs_pkg::IMP_W-1:0]    in_importance,
  input  logic [tpsbs_pkg::SEQ_W-1:0]    in_sequence_number,
  input  logic                           in_end_of_record,
  output logic                           push,
  output tpsbs_pkg::q_entry_t            push_data,
  input  logic                           q_full
);

  logic [tpsbs_pkg::IMP_W-1:0] thr_r, thr_nxt;
  logic [tpsbs_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        stop_r, stop_nxt;
  logic                        accept;
  logic                        keep;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign keep     = !stop_r && (cnt_r < tpsbs_pkg::CNT_W'(tpsbs_pkg::PREFIX_MAX))
                    && (in_importance >= thr_r);

  always_comb begin
    thr_nxt  = cfg_wr_en ? cfg_wr_data : thr_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    if (accept) begin
      if (in_end_of_record) begin
        cnt_nxt  = '0;
        stop_nxt = 1'b0;
      end else if (keep) begin
        cnt_nxt = cnt_r + tpsbs_pkg::CNT_W'(1);
      end else begin
        // first miss or full store ends collection for this record
        stop_nxt = 1'b1;
      end
    end
  end

  // kept points form the leading run, so arrival position equals kept index
  always_comb begin
    push           = accept && (keep || in_end_of_record);
    push_data.keep = keep;
    push_data.eor  = in_end_of_record;
    push_data.seq  = in_sequence_number;
    push_data.pos  = cnt_r[tpsbs_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
    end else begin
      thr_r  <= thr_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

### design/tpsbs_queue.sv
// Short queue between front end and sorter.
module tpsbs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tpsbs_pkg::q_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output tpsbs_pkg::q_entry_t head
);

  tpsbs_pkg::q_entry_t          mem_r [tpsbs_pkg::QDEPTH];
  logic [tpsbs_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tpsbs_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tpsbs_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full    = (cnt_r == tpsbs_pkg::QCNT_W'(tpsbs_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + tpsbs_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + tpsbs_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + tpsbs_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - tpsbs_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### design/tpsbs_back.sv
// Back end: insertion chain sorted by sequence number and result emitter.
module tpsbs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  tpsbs_pkg::q_entry_t               q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tpsbs_pkg::OUT_POS_W-1:0]   out_point_position,
  output logic [tpsbs_pkg::SEQ_W-1:0]       out_point_sequence,
  output logic [tpsbs_pkg::OUT_CNT_W-1:0]   out_kept_count,
  output logic                              out_last_of_run
);

  tpsbs_pkg::bk_state_t          state_r, state_nxt;
  logic [tpsbs_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [tpsbs_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [tpsbs_pkg::CNT_W-1:0]   cnt_ins;
  tpsbs_pkg::cell_t              cells_r   [tpsbs_pkg::PREFIX_MAX];
  tpsbs_pkg::cell_t              cells_nxt [tpsbs_pkg::PREFIX_MAX];
  tpsbs_pkg::cell_t              new_cell;
  logic [tpsbs_pkg::PREFIX_MAX-1:0] gt;
  logic [tpsbs_pkg::PREFIX_MAX-1:0] at_end;
  logic                          do_ins;
  logic                          shift;
  logic                          out_free;

  logic                              out_valid_r, out_valid_nxt;
  logic [tpsbs_pkg::OUT_POS_W-1:0]   pos_r, pos_nxt;
  logic [tpsbs_pkg::SEQ_W-1:0]       seq_r, seq_nxt;
  logic [tpsbs_pkg::OUT_CNT_W-1:0]   kcnt_r, kcnt_nxt;
  logic                              last_r, last_nxt;

  assign out_free     = !out_valid_r || !out_stall;
  assign q_pop        = (state_r == tpsbs_pkg::BK_COLLECT) && !q_empty;
  assign do_ins       = q_pop && q_head.keep;
  assign cnt_ins      = cnt_r + tpsbs_pkg::CNT_W'(do_ins);
  assign new_cell.seq = q_head.seq;
  assign new_cell.pos = q_head.pos;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    shift         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    pos_nxt       = pos_r;
    seq_nxt       = seq_r;
    kcnt_nxt      = kcnt_r;
    last_nxt      = last_r;
    case (state_r)
      tpsbs_pkg::BK_COLLECT: begin
        cnt_nxt = cnt_ins;
        if (q_pop && q_head.eor) begin
          rem_nxt   = cnt_ins;
          state_nxt = tpsbs_pkg::BK_EMIT;
        end
      end
      tpsbs_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kcnt_nxt      = tpsbs_pkg::OUT_CNT_W'(cnt_r);
          if (cnt_r == '0) begin
            // empty record: one result with zero position, sequence and count, marked last
            pos_nxt   = '0;
            seq_nxt   = '0;
            last_nxt  = 1'b1;
            state_nxt = tpsbs_pkg::BK_COLLECT;
          end else begin
            pos_nxt  = tpsbs_pkg::OUT_POS_W'(cells_r[0].pos);
            seq_nxt  = cells_r[0].seq;
            last_nxt = (rem_r == tpsbs_pkg::CNT_W'(1));
            shift    = 1'b1;
            rem_nxt  = rem_r - tpsbs_pkg::CNT_W'(1);
            if (rem_r == tpsbs_pkg::CNT_W'(1)) begin
              cnt_nxt   = '0;
              state_nxt = tpsbs_pkg::BK_COLLECT;
            end
          end
        end
      end
      default: begin
        state_nxt = tpsbs_pkg::BK_COLLECT;
      end
    endcase
  end

  // each cell compares against the new key; the chain opens a gap after
  // the last entry with an equal or smaller key
  for (genvar i = 0; i < tpsbs_pkg::PREFIX_MAX; i++) begin : g_cell
    assign gt[i]     = (tpsbs_pkg::CNT_W'(i) < cnt_r) && (cells_r[i].seq > q_head.seq);
    assign at_end[i] = (tpsbs_pkg::CNT_W'(i) == cnt_r);

    always_comb begin
      cells_nxt[i] = cells_r[i];
      if (do_ins && (gt[i] || at_end[i])) begin
        if (i > 0) begin
          cells_nxt[i] = gt[(i > 0) ? i - 1 : 0] ? cells_r[(i > 0) ? i - 1 : 0] : new_cell;
        end else begin
          cells_nxt[i] = new_cell;
        end
      end else if (shift && (i < tpsbs_pkg::PREFIX_MAX - 1)) begin
        cells_nxt[i] = cells_r[(i < tpsbs_pkg::PREFIX_MAX - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpsbs_pkg::BK_COLLECT;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    seq_r  <= seq_nxt;
    kcnt_r <= kcnt_nxt;
    last_r <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_point_position = pos_r;
  assign out_point_sequence = seq_r;
  assign out_kept_count     = kcnt_r;
  assign out_last_of_run    = last_r;

endmodule

### design/threshold_prefix_sort_by_sequence.sv
// With an idle queue, an end-of-record point passes the queue entry, the sorter state register and the output register.
// Throughput: one point per cycle while a record is collected and the queue is not full (insertion chain).
// Emitting a record (one result per kept point, or one for an empty record) occupies the sorter; the 4-entry
// queue absorbs the next points meanwhile, then in_stall rises until emission ends.
// Reset: synchronous, active-low rst_n clears threshold, counters, state and out_valid;
// the sorted store is not cleared and needs no clearing pass.
module threshold_prefix_sort_by_sequence (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tpsbs_pkg::IMP_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tpsbs_pkg::IMP_W-1:0]       in_importance,
  input  logic [tpsbs_pkg::SEQ_W-1:0]       in_sequence_number,
  input  logic                              in_end_of_record,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tpsbs_pkg::OUT_POS_W-1:0]   out_point_position,
  output logic [tpsbs_pkg::SEQ_W-1:0]       out_point_sequence,
  output logic [tpsbs_pkg::OUT_CNT_W-1:0]   out_kept_count,
  output logic                              out_last_of_run
);

  logic                push;
  tpsbs_pkg::q_entry_t push_data;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  tpsbs_pkg::q_entry_t q_head;

  tpsbs_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_importance      (in_importance),
    .in_sequence_number (in_sequence_number),
    .in_end_of_record   (in_end_of_record),
    .push               (push),
    .push_data          (push_data),
    .q_full             (q_full)
  );

  tpsbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tpsbs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_point_position (out_point_position),
    .out_point_sequence (out_point_sequence),
    .out_kept_count     (out_kept_count),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

### design/tpsbs_checker.sv
// Port-level checker for the threshold prefix sorter, bound to the top level.
module tpsbs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [tpsbs_pkg::OUT_POS_W-1:0]   out_point_position,
  input logic [tpsbs_pkg::SEQ_W-1:0]       out_point_sequence,
  input logic [tpsbs_pkg::OUT_CNT_W-1:0]   out_kept_count,
  input logic                              out_last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_sequence)
      && $stable(out_point_position) && $stable(out_kept_count) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // an empty record gives a single zero result
  a_empty_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kept_count == '0) |->
      out_last_of_run && (out_point_sequence == '0) && (out_point_position == '0))
    else $error("empty record result malformed");

  // kept positions lie inside the kept prefix
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kept_count != '0) |->
      (tpsbs_pkg::PREFIX_MAX > 64) || (7'(out_point_position) < out_kept_count))
    else $error("position outside kept prefix");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind threshold_prefix_sort_by_sequence tpsbs_checker u_tpsbs_checker (.*);

### verif/tb_threshold_prefix_sort_by_sequence.sv
// Testbench for threshold_prefix_sort_by_sequence: directed and random records, scoreboard check.
`timescale 1ns / 1ps

module tb_threshold_prefix_sort_by_sequence;

  localparam int SETTLE_CYCLES = 10;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PREFIX_MAX    = tpsbs_pkg::PREFIX_MAX;
  localparam int IMP_W         = tpsbs_pkg::IMP_W;
  localparam int SEQ_W         = tpsbs_pkg::SEQ_W;
  localparam int OUT_POS_W     = tpsbs_pkg::OUT_POS_W;
  localparam int OUT_CNT_W     = tpsbs_pkg::OUT_CNT_W;

  typedef struct packed {
    logic [OUT_POS_W-1:0] position;
    logic [SEQ_W-1:0]     seq_num;
    logic [OUT_CNT_W-1:0] count;
    logic                 last_flag;
  } sorted_point_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [IMP_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [IMP_W-1:0]     in_importance;
  logic [SEQ_W-1:0]     in_sequence_number;
  logic                 in_end_of_record;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_POS_W-1:0] out_point_position;
  logic [SEQ_W-1:0]     out_point_sequence;
  logic [OUT_CNT_W-1:0] out_kept_count;
  logic                 out_last_of_run;

  // prefix tracker state
  logic [IMP_W-1:0] threshold;
  logic [SEQ_W-1:0] kept_seq [PREFIX_MAX];
  int               kept_pos [PREFIX_MAX];
  int               kept_n;
  int               arrival_n;
  bit               stopped;

  sorted_point_t sorted_points_due[$];
  int            mismatches;
  int            idle_cycles;
  bit            in_gaps;
  bit            out_gaps;

  threshold_prefix_sort_by_sequence dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_importance      (in_importance),
    .in_sequence_number (in_sequence_number),
    .in_end_of_record   (in_end_of_record),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_point_position (out_point_position),
    .out_point_sequence (out_point_sequence),
    .out_kept_count     (out_kept_count),
    .out_last_of_run    (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Insert the point into the sorted prefix; on end of record queue the sorted run.
  function automatic void sort_kept_point(logic [IMP_W-1:0] imp, logic [SEQ_W-1:0] seq,
                                          logic eor);
    int slot;
    int k;
    sorted_point_t sp;
    if (!stopped) begin
      if (kept_n >= PREFIX_MAX || imp < threshold) begin
        stopped = 1'b1;
      end else begin
        slot = kept_n;
        // equal sequence numbers stay behind earlier points
        while (slot > 0 && kept_seq[slot-1] > seq) begin
          kept_seq[slot] = kept_seq[slot-1];
          kept_pos[slot] = kept_pos[slot-1];
          slot--;
        end
        kept_seq[slot] = seq;
        kept_pos[slot] = arrival_n;
        kept_n++;
      end
    end
    if (arrival_n < 65535) arrival_n++;
    if (eor) begin
      if (kept_n == 0) begin
        sp = '{position: '0, seq_num: '0, count: '0, last_flag: 1'b1};
        sorted_points_due.push_back(sp);
      end else begin
        for (k = 0; k < kept_n; k++) begin
          sp.position  = kept_pos[k][OUT_POS_W-1:0];
          sp.seq_num   = kept_seq[k];
          sp.count     = kept_n[OUT_CNT_W-1:0];
          sp.last_flag = (k + 1 == kept_n);
          sorted_points_due.push_back(sp);
        end
      end
      kept_n    = 0;
      arrival_n = 0;
      stopped   = 1'b0;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_point(input logic [IMP_W-1:0] imp, input logic [SEQ_W-1:0] seq,
                            input logic eor);
    while (in_gaps && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_importance      <= imp;
    in_sequence_number <= seq;
    in_end_of_record   <= eor;
    do @(posedge clk); while (in_stall);
    sort_kept_point(imp, seq, eor);
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued result has come back, then settle.
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (sorted_points_due.size() > 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [IMP_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    threshold = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Well-formed records carry non-increasing importance; the rest is noise.
  task automatic send_record(input int len, input bit tidy);
    int  level;
    int  i;
    bit  narrow;
    logic [SEQ_W-1:0] seq;
    level  = $urandom_range(255);
    narrow = $urandom_range(1);
    for (i = 0; i < len; i++) begin
      seq = narrow ? SEQ_W'($urandom_range(7)) : SEQ_W'($urandom);
      send_point(tidy ? IMP_W'(level) : IMP_W'($urandom), seq, i == len - 1);
      level = level - $urandom_range(40);
      if (level < 0) level = 0;
    end
  endtask

  task automatic test_reset_threshold;
    // threshold is zero out of reset: zero importance is kept, ties stay in order
    send_point(8'd255, 16'd5, 1'b0);
    send_point(8'd128, 16'd5, 1'b0);
    send_point(8'd0,   16'd2, 1'b1);
  endtask

  task automatic test_empty_record;
    wait_drained(SETTLE_CYCLES);
    write_threshold(8'd255);
    send_point(8'd254, 16'hFFFF, 1'b1);
    send_point(8'd255, 16'hFFFF, 1'b1);
    send_point(8'd0,   16'h0000, 1'b0);
    send_point(8'd255, 16'h0000, 1'b1);
  endtask

  task automatic test_point_after_stop;
    wait_drained(SETTLE_CYCLES);
    write_threshold(8'd100);
    send_point(8'd200, 16'd300,   1'b0);
    send_point(8'd100, 16'd100,   1'b0);
    send_point(8'd99,  16'd50,    1'b0);
    send_point(8'd250, 16'd10,    1'b0);
    send_point(8'd180, 16'hAAAA,  1'b1);
    send_point(8'd128, 16'h5555,  1'b0);
    send_point(8'd127, 16'h0001,  1'b0);
    send_point(8'd101, 16'h8000,  1'b1);
  endtask

  task automatic test_full_store;
    int i;
    wait_drained(SETTLE_CYCLES);
    write_threshold(8'd16);
    // no idling on either side for the whole record
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    // points past the store depth are dropped; narrow sequences force ties
    for (i = 0; i < PREFIX_MAX + 6; i++)
      send_point(IMP_W'(255 - i), SEQ_W'($urandom_range(15)), i == PREFIX_MAX + 5);
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  task automatic test_random_records;
    int phase;
    int sent;
    int len;
    bit paused;
    for (phase = 0; phase < 4; phase++) begin
      wait_drained(SETTLE_CYCLES);
      write_threshold(IMP_W'($urandom));
      in_gaps  = (phase != 1);
      out_gaps = (phase != 1);
      sent     = 0;
      paused   = 1'b0;
      while (sent < 5) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
        send_record(len, $urandom_range(9) < 8);
        sent += len;
        if (phase == 2 && !paused) begin
          wait_drained(0);
          paused = 1'b1;
        end
      end
    end
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  always @(negedge clk) begin
    out_stall <= out_gaps && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    sorted_point_t sp;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_points_due.size() == 0) begin
        $error("result beat with no expectation: position %0d sequence %0d",
               out_point_position, out_point_sequence);
        mismatches++;
      end else begin
        sp = sorted_points_due.pop_front();
        if (out_point_position !== sp.position) begin
          $error("point_position: expected %0d, actual %0d", sp.position, out_point_position);
          mismatches++;
        end
        if (out_point_sequence !== sp.seq_num) begin
          $error("point_sequence: expected %0d, actual %0d", sp.seq_num, out_point_sequence);
          mismatches++;
        end
        if (out_kept_count !== sp.count) begin
          $error("kept_count: expected %0d, actual %0d", sp.count, out_kept_count);
          mismatches++;
        end
        if (out_last_of_run !== sp.last_flag) begin
          $error("last_of_run: expected %0d, actual %0d", sp.last_flag, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_valid           = 1'b0;
    in_importance      = '0;
    in_sequence_number = '0;
    in_end_of_record   = 1'b0;
    out_stall          = 1'b0;
    threshold          = '0;
    kept_n             = 0;
    arrival_n          = 0;
    stopped            = 1'b0;
    mismatches         = 0;
    idle_cycles        = 0;
    in_gaps            = 1'b1;
    out_gaps           = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_threshold();
    test_empty_record();
    test_point_after_stop();
    test_full_store();
    test_random_records();

    wait_drained(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
